FILE: design/rld_pkg.sv
// ----------------------------------------------------------------------------
// rld_pkg
// Shared types and constants for the 48-bit luxury subtract-with-borrow generator.
// ----------------------------------------------------------------------------
package rld_pkg;

	localparam int WordW    = 24;
	localparam int AddrW    = 7;
	localparam int StoreLen = 96;
	localparam int SeedW    = 31;
	localparam int CountW   = 7;
	localparam int ValueW   = 48;

	localparam logic [CountW-1:0] MaxOut   = 7'd64;
	localparam logic [8:0]        StepsLo  = 9'd202;
	localparam logic [8:0]        StepsHi  = 9'd397;
	localparam logic [3:0]        VecLast  = 4'd11;
	localparam logic [4:0]        SeedTapB = 5'd18;
	localparam logic [4:0]        TapLast  = 5'd30;
	localparam logic [4:0]        BitLast  = 5'd23;
	localparam logic [1:0]        LuxHigh  = 2'd2;

	// One store write, as driven by the seeding unit.
	typedef struct packed {
		logic                 we;
		logic [AddrW-1:0]     addr;
		logic [WordW-1:0]     data;
	} rld_wr_t;

endpackage

FILE: design/rld_req_if.sv
// ----------------------------------------------------------------------------
// rld_req_if
// Request channel: number of values wanted.
// ----------------------------------------------------------------------------
interface rld_req_if;
	import rld_pkg::*;
	logic              valid;
	logic              ready;
	logic [CountW-1:0] count;

	modport source (output valid, output count, input ready);
	modport sink (input valid, input count, output ready);
endinterface

FILE: design/rld_rsp_if.sv
// ----------------------------------------------------------------------------
// rld_rsp_if
// Response channel: one 48-bit random value per transfer.
// ----------------------------------------------------------------------------
interface rld_rsp_if;
	import rld_pkg::*;
	logic              valid;
	logic              ready;
	logic [ValueW-1:0] random_value;
	logic              last;

	modport source (output valid, output random_value, output last, input ready);
	modport sink (input valid, input random_value, input last, output ready);
endinterface

FILE: design/ranlux_double_generator.sv
// ----------------------------------------------------------------------------
// ranlux_double_generator
// Subtract-with-borrow generator, 96 x 24-bit store in one two-read memory.
// One value at a time: NEXT, READ, LOAD and OUT; a value is taken before the next.
// A refill runs every 48 values: a vector step reads eight word pairs (one word
// pair per cycle through the memory read ports), 202 or 397 steps, then a drain.
// Seeding runs on the first request after reset or a config write.
// Reset: registers back to level 1, seed 1; store contents undefined until seeded.
// ----------------------------------------------------------------------------
module ranlux_double_generator
	import rld_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	rld_req_if.sink     req,
	rld_rsp_if.source   rsp
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SEED   = 3'd1;
	localparam logic [2:0] ST_NEXT   = 3'd2;
	localparam logic [2:0] ST_REFILL = 3'd3;
	localparam logic [2:0] ST_DRAIN  = 3'd4;
	localparam logic [2:0] ST_READ   = 3'd5;
	localparam logic [2:0] ST_LOAD   = 3'd6;
	localparam logic [2:0] ST_OUT    = 3'd7;

	localparam logic REG_LUX  = 1'b0;
	localparam logic REG_SEED = 1'b1;

	logic [2:0]        state_q;
	logic [1:0]        lux_q;
	logic [SeedW-1:0]  seed_q;
	logic              seeded_q;
	logic [3:0]        borrow_q;
	logic [3:0]        vi_q;
	logic [3:0]        vj_q;
	logic [AddrW-1:0]  rp_q;
	logic [AddrW-1:0]  refill_q;
	logic [CountW-1:0] rem_q;
	logic [8:0]        step_q;
	logic [2:0]        phase_q;
	logic              neg_q;
	logic              out_valid_q;
	logic [ValueW-1:0] out_value_q;
	logic              out_last_q;

	logic              valid_s1;
	logic [2:0]        phase_s1;
	logic [AddrW-1:0]  waddr_s1;

	logic [WordW-1:0]  mem [StoreLen];
	logic [WordW-1:0]  rd_a_q;
	logic [WordW-1:0]  rd_b_q;
	logic [AddrW-1:0]  rd_addr_a;
	logic [AddrW-1:0]  rd_addr_b;
	logic              mem_we;
	logic [AddrW-1:0]  mem_waddr;
	logic [WordW-1:0]  mem_wdata;

	logic              cfg_wr;
	logic              req_acc;
	logic [CountW-1:0] n_sat;
	logic              seed_start;
	rld_wr_t           seed_wr;
	logic              seed_done;
	logic [8:0]        step_last;
	logic [2:0]        off;
	logic [AddrW-1:0]  p_inc;
	logic [AddrW-1:0]  p_next;
	logic [AddrW-1:0]  rp_hi;
	logic [1:0]        lane_s1;
	logic [WordW:0]    sub_s1;
	logic              neg_s1;
	logic [WordW-1:0]  res_s1;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign prdata  = (paddr[2] == REG_SEED) ? {1'b0, seed_q} : {30'd0, lux_q};

	assign req.ready  = (state_q == ST_IDLE);
	assign req_acc    = req.valid && req.ready;
	assign n_sat      = (req.count > MaxOut) ? MaxOut : req.count;
	assign seed_start = req_acc && !seeded_q;

	assign rsp.valid        = out_valid_q;
	assign rsp.random_value = out_value_q;
	assign rsp.last         = out_last_q;

	assign step_last = ((lux_q == LuxHigh) ? StepsHi : StepsLo) - 9'd1;

	// word order per step: low lane 0, high lane 0, low lane 1, ...
	assign off    = {phase_q[0], phase_q[2:1]};
	assign p_inc  = (rp_q[1:0] == 2'd3) ? rp_q + 7'd5 : rp_q + 7'd1;
	assign p_next = (p_inc >= 7'(StoreLen)) ? p_inc - 7'(StoreLen) : p_inc;
	assign rp_hi  = (rp_q >= 7'(StoreLen - 4)) ? rp_q - 7'(StoreLen - 4) : rp_q + 7'd4;

	always_comb begin
		if (state_q == ST_REFILL) begin
			rd_addr_a = {vi_q, off};
			rd_addr_b = {vj_q, off};
		end else begin
			rd_addr_a = rp_q;
			rd_addr_b = rp_hi;
		end
	end

	// vector step arithmetic on xi (port a) and xj (port b)
	assign lane_s1 = phase_s1[2:1];
	assign sub_s1  = phase_s1[0] ? ({1'b0, rd_a_q} + {{WordW{1'b0}}, neg_q})
	                             : ({1'b0, rd_a_q} + {{WordW{1'b0}}, borrow_q[lane_s1]});
	assign neg_s1  = ({1'b0, rd_b_q} < sub_s1);
	assign res_s1  = rd_b_q - sub_s1[WordW-1:0];

	assign mem_we    = valid_s1 || seed_wr.we;
	assign mem_waddr = valid_s1 ? waddr_s1 : seed_wr.addr;
	assign mem_wdata = valid_s1 ? res_s1 : seed_wr.data;

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_waddr] <= mem_wdata;
		rd_a_q <= mem[rd_addr_a];
		rd_b_q <= mem[rd_addr_b];
	end

	rld_seeder u_seeder (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (seed_start),
		.seed   (seed_q),
		.wr     (seed_wr),
		.done   (seed_done)
	);

	always_ff @(posedge clk) begin
		phase_s1 <= phase_q;
		waddr_s1 <= rd_addr_a;
		if (valid_s1 && !phase_s1[0])
			neg_q <= neg_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			lux_q       <= 2'd1;
			seed_q      <= 31'd1;
			seeded_q    <= 1'b0;
			borrow_q    <= '0;
			vi_q        <= 4'd0;
			vj_q        <= 4'd7;
			rp_q        <= 7'd91;
			refill_q    <= 7'd0;
			rem_q       <= '0;
			step_q      <= '0;
			phase_q     <= '0;
			out_valid_q <= 1'b0;
			valid_s1    <= 1'b0;
		end else begin
			valid_s1 <= (state_q == ST_REFILL);
			if (valid_s1 && phase_s1[0])
				borrow_q[lane_s1] <= neg_s1;
			if (cfg_wr) begin
				seeded_q <= 1'b0;
				if (paddr[2] == REG_LUX)
					lux_q <= pwdata[1:0];
				else
					seed_q <= pwdata[SeedW-1:0];
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req_acc) begin
						rem_q <= n_sat;
						if (!seeded_q)
							state_q <= ST_SEED;
						else if (n_sat != '0)
							state_q <= ST_NEXT;
					end
				end
				ST_SEED: begin
					if (seed_done) begin
						seeded_q <= 1'b1;
						borrow_q <= '0;
						vi_q     <= 4'd0;
						vj_q     <= 4'd7;
						rp_q     <= 7'd91;
						refill_q <= 7'd0;
						state_q  <= (rem_q == '0) ? ST_IDLE : ST_NEXT;
					end
				end
				ST_NEXT: begin
					rp_q <= p_next;
					if (p_next == refill_q) begin
						step_q  <= '0;
						phase_q <= '0;
						state_q <= ST_REFILL;
					end else begin
						state_q <= ST_READ;
					end
				end
				ST_REFILL: begin
					phase_q <= phase_q + 3'd1;
					if (phase_q == 3'd7) begin
						vi_q   <= (vi_q == VecLast) ? 4'd0 : vi_q + 4'd1;
						vj_q   <= (vj_q == VecLast) ? 4'd0 : vj_q + 4'd1;
						step_q <= step_q + 9'd1;
						if (step_q == step_last)
							state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					rp_q     <= {vi_q, 3'd0};
					refill_q <= {vi_q, 3'd0};
					state_q  <= ST_READ;
				end
				ST_READ: begin
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					out_valid_q <= 1'b1;
					rem_q       <= rem_q - 7'd1;
					state_q     <= ST_OUT;
				end
				ST_OUT: begin
					if (rsp.ready) begin
						out_valid_q <= 1'b0;
						state_q     <= (rem_q == '0) ? ST_IDLE : ST_NEXT;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_LOAD) begin
			out_value_q <= {rd_b_q, rd_a_q};
			out_last_q  <= (rem_q == 7'd1);
		end
	end

endmodule

FILE: design/rld_seeder.sv
// ----------------------------------------------------------------------------
// rld_seeder
// Bit-serial seeding: a 31-bit shift register with taps 18 apart produces one
// bit per cycle; every 24 bits form a store word that is written out.
// ----------------------------------------------------------------------------
module rld_seeder
	import rld_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [SeedW-1:0] seed,
	output rld_wr_t          wr,
	output logic             done
);

	logic             busy_q;
	logic [SeedW-1:0] shift_q;
	logic [4:0]       tap_a_q;
	logic [4:0]       tap_b_q;
	logic [4:0]       bit_q;
	logic [4:0]       k_q;
	logic [1:0]       lane_q;
	logic [WordW-1:0] w_q;

	logic             bit_a;
	logic [WordW-1:0] w_next;
	logic             word_end;
	logic             last_word;

	assign bit_a     = shift_q[tap_a_q];
	assign w_next    = {w_q[WordW-2:0], bit_a};
	assign word_end  = busy_q && (bit_q == BitLast);
	assign last_word = (k_q == BitLast) && (lane_q == 2'd3);

	// lanes other than k mod 4 are stored complemented
	assign wr.we   = word_end;
	assign wr.addr = {k_q, lane_q};
	assign wr.data = (k_q[1:0] != lane_q) ? ~w_next : w_next;
	assign done    = word_end && last_word;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			bit_q   <= '0;
			k_q     <= '0;
			lane_q  <= '0;
			tap_a_q <= '0;
			tap_b_q <= SeedTapB;
			shift_q <= '0;
		end else if (start) begin
			busy_q  <= 1'b1;
			bit_q   <= '0;
			k_q     <= '0;
			lane_q  <= '0;
			tap_a_q <= '0;
			tap_b_q <= SeedTapB;
			shift_q <= seed;
		end else if (busy_q) begin
			shift_q[tap_a_q] <= shift_q[tap_a_q] ^ shift_q[tap_b_q];
			tap_a_q <= (tap_a_q == TapLast) ? 5'd0 : tap_a_q + 5'd1;
			tap_b_q <= (tap_b_q == TapLast) ? 5'd0 : tap_b_q + 5'd1;
			if (word_end) begin
				bit_q <= '0;
				if (k_q == BitLast) begin
					k_q    <= '0;
					lane_q <= lane_q + 2'd1;
					if (last_word)
						busy_q <= 1'b0;
				end else begin
					k_q <= k_q + 5'd1;
				end
			end else begin
				bit_q <= bit_q + 5'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start)
			w_q <= '0;
		else if (busy_q)
			w_q <= w_next;
	end

endmodule
